FILE: rtl/cisp_pkg.sv
// shared constants for the cartridge image stream parser
package cisp_pkg;

  localparam int END_BITS = 23;  // wide enough for the largest region end

  localparam logic [END_BITS-1:0] HEADER_BYTES  = 23'd16;
  localparam logic [END_BITS-1:0] TRAINER_BYTES = 23'd512;
  localparam int                  PRG_SHIFT     = 14;  // 16 KB per bank
  localparam int                  CHR_SHIFT     = 13;  // 8 KB per bank
  localparam logic [23:0]         OFFSET_MAX    = 24'hFFFFFF;

  localparam logic [2:0] REGION_HEADER   = 3'd0;
  localparam logic [2:0] REGION_TRAINER  = 3'd1;
  localparam logic [2:0] REGION_PRG      = 3'd2;
  localparam logic [2:0] REGION_CHR      = 3'd3;
  localparam logic [2:0] REGION_TRAILING = 3'd4;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_TOO_SMALL = 3'd1;
  localparam logic [2:0] STATUS_BAD_MAGIC = 3'd2;
  localparam logic [2:0] STATUS_PRG_SHORT = 3'd3;
  localparam logic [2:0] STATUS_CHR_SHORT = 3'd4;

  localparam logic [7:0] FLAGS_VERTICAL = 8'h01;
  localparam logic [7:0] FLAGS_TRAINER  = 8'h04;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] value;
    unique case (idx)
      2'd0:    value = 8'h4E;
      2'd1:    value = 8'h45;
      2'd2:    value = 8'h53;
      default: value = 8'h1A;
    endcase
    return value;
  endfunction

endpackage

FILE: rtl/cartridge_image_stream_parser_top.sv
// cartridge image stream parser: header decode, region routing and final status
//
// input stream: one image byte per transaction on s_axis, tlast on the final byte.
// output stream: one result per input byte on m_axis; tlast marks the result of
// the final byte, which carries the status (ok, too small, bad magic, program or
// character truncated). tuser gives the region of the byte, tdata the byte, its
// offset inside the region and the header fields as known after that byte.
// a byte accepted is held in the result register and offered from the next
// cycle on. throughput is one byte per cycle while m_axis_tready is high, set
// by the position counter and region compare done between the state registers
// and the result register. region boundaries are held in registers refreshed
// on every byte. when m_axis_tready is low the result register holds its
// transaction and s_axis_tready drops; a new byte is taken in the same cycle
// the old result leaves. reset (rst, synchronous) empties the result register
// and returns the position and header state to the start of a new image; the
// position and header state do so too after every byte marked with tlast.
module cartridge_image_stream_parser_top
  import cisp_pkg::*;
#(
  parameter int POSITION_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_in
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // byte_out[7:0], offset[31:8], status[34:32], mapper number[42:35],
  // vertical_mirroring[43], character ram flag[44], prg_bank_count_out[52:45],
  // chr_bank_count_out[60:53], zero fill[63:61]
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tlast,
  output logic [2:0]  m_axis_tuser    // region
);

  localparam int PW = POSITION_BITS;
  localparam int WW = (PW > 24) ? PW : 24;

  // image state
  logic [PW-1:0]       byte_position;
  logic                magic_good;
  logic [7:0]          prg_bank_count;
  logic [7:0]          chr_bank_count;
  logic [7:0]          header_flags_low;
  logic [3:0]          mapper_high_nibble;
  logic [END_BITS-1:0] prg_base;
  logic [END_BITS-1:0] prg_end;
  logic [END_BITS-1:0] chr_end;

  logic [PW-1:0]       byte_position_next;
  logic                magic_good_next;
  logic [7:0]          prg_bank_count_next;
  logic [7:0]          chr_bank_count_next;
  logic [7:0]          header_flags_low_next;
  logic [3:0]          mapper_high_nibble_next;
  logic [END_BITS-1:0] prg_base_next;
  logic [END_BITS-1:0] prg_end_next;
  logic [END_BITS-1:0] chr_end_next;

  // result register
  logic        out_valid;
  logic [2:0]  res_region;
  logic [7:0]  res_byte;
  logic [23:0] res_offset;
  logic        res_final;
  logic [2:0]  res_status;
  logic [7:0]  res_mapper;
  logic        res_vertical;
  logic        res_chr_ram;
  logic [7:0]  res_prg_count;
  logic [7:0]  res_chr_count;

  logic        accept_in;
  logic        in_header;
  logic [2:0]  region_next;
  logic [PW-1:0] diff_next;
  logic [WW-1:0] diff_wide;
  logic [23:0] offset_next;
  logic [2:0]  status_next;
  logic [PW:0] image_size;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept_in     = s_axis_tvalid && s_axis_tready;
  assign in_header     = byte_position < PW'(HEADER_BYTES);

  // header capture for the current byte
  always_comb begin
    magic_good_next         = magic_good;
    prg_bank_count_next     = prg_bank_count;
    chr_bank_count_next     = chr_bank_count;
    header_flags_low_next   = header_flags_low;
    mapper_high_nibble_next = mapper_high_nibble;
    if (byte_position < PW'(4)) begin
      if (s_axis_tdata != magic_byte(byte_position[1:0])) begin
        magic_good_next = 1'b0;
      end
    end else if (byte_position == PW'(4)) begin
      prg_bank_count_next = s_axis_tdata;
    end else if (byte_position == PW'(5)) begin
      chr_bank_count_next = s_axis_tdata;
    end else if (byte_position == PW'(6)) begin
      header_flags_low_next = s_axis_tdata;
    end else if (byte_position == PW'(7)) begin
      mapper_high_nibble_next = s_axis_tdata[7:4];
    end
  end

  // boundaries settle by byte 8, long before any byte leaves the header
  always_comb begin
    prg_base_next = HEADER_BYTES +
      (((header_flags_low_next & FLAGS_TRAINER) != 8'h00) ? TRAINER_BYTES : '0);
    prg_end_next = prg_base_next +
      (END_BITS'(prg_bank_count_next) << PRG_SHIFT);
    chr_end_next = prg_end_next +
      (END_BITS'(chr_bank_count_next) << CHR_SHIFT);
  end

  always_comb begin
    if (in_header) begin
      region_next = REGION_HEADER;
      diff_next   = byte_position;
    end else if (byte_position < PW'(prg_base)) begin
      region_next = REGION_TRAINER;
      diff_next   = byte_position - PW'(HEADER_BYTES);
    end else if (byte_position < PW'(prg_end)) begin
      region_next = REGION_PRG;
      diff_next   = byte_position - PW'(prg_base);
    end else if (byte_position < PW'(chr_end)) begin
      region_next = REGION_CHR;
      diff_next   = byte_position - PW'(prg_end);
    end else begin
      region_next = REGION_TRAILING;
      diff_next   = byte_position - PW'(chr_end);
    end
    diff_wide   = WW'(diff_next);
    offset_next = (diff_wide > WW'(OFFSET_MAX)) ? OFFSET_MAX : diff_wide[23:0];
  end

  // status only matters on the last byte; size compares use position + 1
  always_comb begin
    image_size  = {1'b0, byte_position} + (PW+1)'(1);
    status_next = STATUS_OK;
    if (s_axis_tlast) begin
      if (image_size < (PW+1)'(HEADER_BYTES)) begin
        status_next = STATUS_TOO_SMALL;
      end else if (!magic_good_next) begin
        status_next = STATUS_BAD_MAGIC;
      end else if (image_size < (PW+1)'(prg_end)) begin
        status_next = STATUS_PRG_SHORT;
      end else if (chr_bank_count_next != 8'h00 && image_size < (PW+1)'(chr_end)) begin
        status_next = STATUS_CHR_SHORT;
      end
    end
  end

  assign byte_position_next = (&byte_position) ? byte_position
                                               : byte_position + PW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      magic_good         <= 1'b1;
      prg_bank_count     <= '0;
      chr_bank_count     <= '0;
      header_flags_low   <= '0;
      mapper_high_nibble <= '0;
      prg_base           <= HEADER_BYTES;
      prg_end            <= HEADER_BYTES;
      chr_end            <= HEADER_BYTES;
    end else if (accept_in) begin
      if (s_axis_tlast) begin
        byte_position      <= '0;
        magic_good         <= 1'b1;
        prg_bank_count     <= '0;
        chr_bank_count     <= '0;
        header_flags_low   <= '0;
        mapper_high_nibble <= '0;
        prg_base           <= HEADER_BYTES;
        prg_end            <= HEADER_BYTES;
        chr_end            <= HEADER_BYTES;
      end else begin
        byte_position      <= byte_position_next;
        magic_good         <= magic_good_next;
        prg_bank_count     <= prg_bank_count_next;
        chr_bank_count     <= chr_bank_count_next;
        header_flags_low   <= header_flags_low_next;
        mapper_high_nibble <= mapper_high_nibble_next;
        prg_base           <= prg_base_next;
        prg_end            <= prg_end_next;
        chr_end            <= chr_end_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept_in) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      res_region    <= region_next;
      res_byte      <= s_axis_tdata;
      res_offset    <= offset_next;
      res_final     <= s_axis_tlast;
      res_status    <= status_next;
      res_mapper    <= {mapper_high_nibble_next, header_flags_low_next[7:4]};
      res_vertical  <= (header_flags_low_next & FLAGS_VERTICAL) != 8'h00;
      res_chr_ram   <= chr_bank_count_next == 8'h00;
      res_prg_count <= prg_bank_count_next;
      res_chr_count <= chr_bank_count_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = res_final;
  assign m_axis_tuser  = res_region;
  assign m_axis_tdata  = {3'b000, res_chr_count, res_prg_count, res_chr_ram,
                          res_vertical, res_mapper, res_status, res_offset,
                          res_byte};

`ifndef NO_ASSERTIONS
  // a new image starts right after a last-byte transaction
  a_restart: assert property (@(posedge clk) disable iff (rst)
    accept_in && s_axis_tlast |=> byte_position == '0 && magic_good)
    else $error("position not cleared after last byte");

  // status is only reported on the final result
  a_status_final: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> res_status == STATUS_OK)
    else $error("status on a non-final result");

  // header bytes carry their own position as offset
  a_header_offset: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res_region == REGION_HEADER |-> res_offset < 24'd16)
    else $error("header offset out of range");

  // region boundaries stay ordered
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    prg_base <= prg_end && prg_end <= chr_end && prg_base >= HEADER_BYTES)
    else $error("region boundaries out of order");

  // an image that is still in its header cannot report trailing data
  a_header_region: assert property (@(posedge clk) disable iff (rst)
    accept_in && in_header |=> res_region == REGION_HEADER)
    else $error("byte inside header routed elsewhere");
`endif

endmodule
